// File: hw/rtl/spp_pkg.sv
// ---------------------------------------------------------------------------
// Servo status packet parser package
// Shared types and constants for the status packet parser.
// ---------------------------------------------------------------------------
package spp_pkg;

  localparam logic [7:0] HDR_BYTE = 8'hFF;
  localparam logic [7:0] MIN_LEN  = 8'd2;

  // Parser position, one-hot.
  typedef enum logic [6:0] {
    PH_HUNT1 = 7'b0000001,
    PH_HUNT2 = 7'b0000010,
    PH_ID    = 7'b0000100,
    PH_LEN   = 7'b0001000,
    PH_ERR   = 7'b0010000,
    PH_PARAM = 7'b0100000,
    PH_CSUM  = 7'b1000000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PARAM    = 2'd0,
    KIND_GOOD     = 2'd1,
    KIND_CSUM_ERR = 2'd2,
    KIND_BAD_LEN  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] servo_id;
    logic [7:0] error_flags;
    logic [7:0] data_byte;
    logic [7:0] param_index;
    logic       last;
  } res_t;

endpackage

// File: hw/rtl/servo_status_packet_parser.sv
// Each byte passes the input register, and its result is then loaded into the output register.
// Throughput: one byte per cycle unless a result waits; the input register holds one byte.
// Bytes that produce no result pass through without waiting on the output side.
// Reset (rst_ni low, asynchronous) empties both registers and restarts the header hunt.
// ---------------------------------------------------------------------------
// Servo status packet parser
// Hunts for the two-byte header, emits each parameter byte and a final verdict.
// ---------------------------------------------------------------------------
module servo_status_packet_parser
  import spp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [7:0] servo_id, [15:8] error_flags,
                                        // [23:16] data_byte, [31:24] param_index
  output logic [1:0]  m_axis_tuser_o,   // [1:0] kind
  output logic        m_axis_tlast_o    // last
);

  logic       byte_valid;
  logic [7:0] rx_byte;
  logic       take;
  logic       out_free;
  logic       res_valid;
  res_t       res;
  res_t       res_out;

  spp_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .s_byte_i    (s_axis_tdata_i),
    .byte_valid_o(byte_valid),
    .byte_o      (rx_byte),
    .take_i      (take)
  );

  spp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(byte_valid),
    .byte_i      (rx_byte),
    .out_free_i  (out_free),
    .take_o      (take),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  spp_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (res_valid),
    .res_i    (res),
    .free_o   (out_free),
    .m_valid_o(m_axis_tvalid_o),
    .m_ready_i(m_axis_tready_i),
    .res_o    (res_out)
  );

  assign m_axis_tdata_o = {res_out.param_index, res_out.data_byte,
                           res_out.error_flags, res_out.servo_id};
  assign m_axis_tuser_o = res_out.kind;
  assign m_axis_tlast_o = res_out.last;

endmodule

// File: hw/rtl/spp_in_stage.sv
// ---------------------------------------------------------------------------
// Input register
// Holds one received byte until the parser core takes it.
// ---------------------------------------------------------------------------
module spp_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  logic [7:0] s_byte_i,
  output logic       byte_valid_o,
  output logic [7:0] byte_o,
  input  logic       take_i
);

  logic       valid_q;
  logic [7:0] byte_q;

  assign s_ready_o    = !valid_q || take_i;
  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_valid_i && s_ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      byte_q <= s_byte_i;
    end
  end

endmodule

// File: hw/rtl/spp_core.sv
// ---------------------------------------------------------------------------
// Parser core
// Packet state machine with the running checksum; builds a result for each parameter byte and for the verdict.
// ---------------------------------------------------------------------------
module spp_core
  import spp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] byte_i,
  input  logic       out_free_i,
  output logic       take_o,
  output logic       res_valid_o,
  output res_t       res_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] id_q, id_d;
  logic [7:0] err_q, err_d;
  logic [7:0] left_q, left_d;
  logic [7:0] count_q, count_d;
  logic [7:0] sum_q, sum_d;
  logic       has_res;

  always_comb begin
    phase_d = phase_q;
    id_d    = id_q;
    err_d   = err_q;
    left_d  = left_q;
    count_d = count_q;
    sum_d   = sum_q;
    has_res = 1'b0;
    res_o.kind        = KIND_PARAM;
    res_o.servo_id    = id_q;
    res_o.error_flags = err_q;
    res_o.data_byte   = byte_i;
    res_o.param_index = count_q;
    res_o.last        = 1'b0;
    unique case (phase_q)
      PH_HUNT2: begin
        phase_d = (byte_i == HDR_BYTE) ? PH_ID : PH_HUNT1;
      end
      PH_ID: begin
        id_d    = byte_i;
        sum_d   = byte_i;
        phase_d = PH_LEN;
      end
      PH_LEN: begin
        if (byte_i < MIN_LEN) begin
          // No error byte has arrived, so flags, data and index read as zero.
          has_res           = 1'b1;
          res_o.kind        = KIND_BAD_LEN;
          res_o.error_flags = '0;
          res_o.data_byte   = '0;
          res_o.param_index = '0;
          res_o.last        = 1'b1;
          phase_d           = PH_HUNT1;
        end else begin
          left_d  = byte_i - MIN_LEN;
          sum_d   = sum_q + byte_i;
          phase_d = PH_ERR;
        end
      end
      PH_ERR: begin
        err_d   = byte_i;
        sum_d   = sum_q + byte_i;
        count_d = '0;
        phase_d = (left_q != '0) ? PH_PARAM : PH_CSUM;
      end
      PH_PARAM: begin
        has_res = 1'b1;
        sum_d   = sum_q + byte_i;
        count_d = count_q + 8'd1;
        left_d  = left_q - 8'd1;
        if (left_d == '0) begin
          phase_d = PH_CSUM;
        end
      end
      PH_CSUM: begin
        has_res           = 1'b1;
        res_o.kind        = (~sum_q == byte_i) ? KIND_GOOD : KIND_CSUM_ERR;
        res_o.param_index = '0;
        res_o.last        = 1'b1;
        phase_d           = PH_HUNT1;
      end
      default: begin
        phase_d = (byte_i == HDR_BYTE) ? PH_HUNT2 : PH_HUNT1;
      end
    endcase
  end

  // A byte that yields no result never waits on the output register.
  assign take_o      = byte_valid_i && (!has_res || out_free_i);
  assign res_valid_o = take_o && has_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT1;
      id_q    <= '0;
      err_q   <= '0;
      left_q  <= '0;
      count_q <= '0;
      sum_q   <= '0;
    end else if (take_o) begin
      phase_q <= phase_d;
      id_q    <= id_d;
      err_q   <= err_d;
      left_q  <= left_d;
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

`ifndef SYNTH
  a_res_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> out_free_i)
    else $error("result issued while output register is full");

  a_bad_len_rehunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == KIND_BAD_LEN) |=> phase_q == PH_HUNT1)
    else $error("bad length did not restart the header hunt");

  a_param_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && phase_q == PH_PARAM) |=>
      (count_q == $past(count_q) + 8'd1) && (left_q == $past(left_q) - 8'd1))
    else $error("parameter counters out of step");

  a_sum_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && phase_q == PH_ID) |=> sum_q == id_q)
    else $error("checksum not seeded with the servo id");
`endif

endmodule

// File: hw/rtl/spp_out_stage.sv
// ---------------------------------------------------------------------------
// Output register
// Holds one result until the downstream side completes the transfer.
// ---------------------------------------------------------------------------
module spp_out_stage
  import spp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  output logic free_o,
  output logic m_valid_o,
  input  logic m_ready_i,
  output res_t res_o
);

  logic valid_q;
  res_t res_q;

  assign free_o    = !valid_q || m_ready_i;
  assign m_valid_o = valid_q;
  assign res_o     = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (m_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Servo status packet parser testbench
// Streams header hunts, good, bad and malformed status packets into the
// parser under random stalls on both sides, and checks every parameter
// and verdict transfer against a cycle-free model of the packet grammar.
// ---------------------------------------------------------------------------

class status_packet_model;
  spp_pkg::phase_e  parse_pos;
  logic [7:0]       pkt_id;
  logic [7:0]       pkt_err;
  logic [7:0]       params_left;
  logic [7:0]       param_cnt;
  logic [7:0]       csum_acc;
  spp_pkg::res_t    pending_results[$];
  int               fails;

  function new();
    parse_pos   = spp_pkg::PH_HUNT1;
    pkt_id      = '0;
    pkt_err     = '0;
    params_left = '0;
    param_cnt   = '0;
    csum_acc    = '0;
    fails       = 0;
  endfunction

  function spp_pkg::res_t make_result(spp_pkg::kind_e kind, logic [7:0] flags,
                                      logic [7:0] data, logic [7:0] idx, logic last);
    spp_pkg::res_t r;
    r.kind        = kind;
    r.servo_id    = pkt_id;
    r.error_flags = flags;
    r.data_byte   = data;
    r.param_index = idx;
    r.last        = last;
    return r;
  endfunction

  // Advances the parser by one accepted byte and queues the result it causes.
  function void take_rx_byte(logic [7:0] b);
    logic [7:0] want_csum;
    case (parse_pos)
      spp_pkg::PH_HUNT2: begin
        parse_pos = (b == spp_pkg::HDR_BYTE) ? spp_pkg::PH_ID : spp_pkg::PH_HUNT1;
      end
      spp_pkg::PH_ID: begin
        pkt_id    = b;
        csum_acc  = b;
        parse_pos = spp_pkg::PH_LEN;
      end
      spp_pkg::PH_LEN: begin
        if (b < spp_pkg::MIN_LEN) begin
          pending_results.push_back(make_result(spp_pkg::KIND_BAD_LEN, 8'd0, 8'd0, 8'd0,
                                                1'b1));
          parse_pos = spp_pkg::PH_HUNT1;
        end else begin
          params_left = b - spp_pkg::MIN_LEN;
          csum_acc    = csum_acc + b;
          parse_pos   = spp_pkg::PH_ERR;
        end
      end
      spp_pkg::PH_ERR: begin
        pkt_err   = b;
        csum_acc  = csum_acc + b;
        param_cnt = '0;
        parse_pos = (params_left != 0) ? spp_pkg::PH_PARAM : spp_pkg::PH_CSUM;
      end
      spp_pkg::PH_PARAM: begin
        pending_results.push_back(make_result(spp_pkg::KIND_PARAM, pkt_err, b, param_cnt,
                                              1'b0));
        csum_acc    = csum_acc + b;
        param_cnt   = param_cnt + 8'd1;
        params_left = params_left - 8'd1;
        if (params_left == 0) parse_pos = spp_pkg::PH_CSUM;
      end
      spp_pkg::PH_CSUM: begin
        want_csum = ~csum_acc;
        pending_results.push_back(make_result((want_csum == b) ? spp_pkg::KIND_GOOD :
                                              spp_pkg::KIND_CSUM_ERR, pkt_err, b, 8'd0,
                                              1'b1));
        parse_pos = spp_pkg::PH_HUNT1;
      end
      default: begin
        parse_pos = (b == spp_pkg::HDR_BYTE) ? spp_pkg::PH_HUNT2 : spp_pkg::PH_HUNT1;
      end
    endcase
  endfunction

  function int outstanding();
    return pending_results.size();
  endfunction

  task report(string msg);
    $display("MISMATCH: %s", msg);
    fails++;
  endtask

  task check_parsed(spp_pkg::res_t got);
    spp_pkg::res_t want;
    if (pending_results.size() == 0) begin
      report($sformatf("unexpected result kind %0d id %0h data %0h", got.kind,
                       got.servo_id, got.data_byte));
      return;
    end
    want = pending_results.pop_front();
    if (got.kind != want.kind)
      report($sformatf("kind %0d, want %0d", got.kind, want.kind));
    if (got.servo_id != want.servo_id)
      report($sformatf("servo_id %0h, want %0h", got.servo_id, want.servo_id));
    if (got.error_flags != want.error_flags)
      report($sformatf("error_flags %0h, want %0h", got.error_flags, want.error_flags));
    if (got.data_byte != want.data_byte)
      report($sformatf("data_byte %0h, want %0h", got.data_byte, want.data_byte));
    if (got.param_index != want.param_index)
      report($sformatf("param_index %0d, want %0d", got.param_index, want.param_index));
    if (got.last != want.last)
      report($sformatf("last %0b, want %0b", got.last, want.last));
  endtask
endclass

module tb;
  import spp_pkg::*;

  localparam int SETTLE_CYCLES = 10;
  localparam int TARGET_BYTES  = 1900;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  status_packet_model model = new();
  int src_idle_pct  = 33;
  int sink_idle_pct = 33;
  int sink_hold_req = 0;
  int stream_bytes  = 0;

  servo_status_packet_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // Results side: checks each transfer and decides the next ready, including
  // the long hold-off that backs the parser up.
  initial begin
    res_t got;
    int   hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got.kind        = kind_e'(m_axis_tuser);
        got.servo_id    = m_axis_tdata[7:0];
        got.error_flags = m_axis_tdata[15:8];
        got.data_byte   = m_axis_tdata[23:16];
        got.param_index = m_axis_tdata[31:24];
        got.last        = m_axis_tlast;
        model.check_parsed(got);
      end
      if (sink_hold_req != 0) begin
        hold_left     = sink_hold_req;
        sink_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    model.take_rx_byte(b);
  endtask

  // Lowers valid and waits until the parser has nothing left to deliver.
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (model.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_packet(input logic [7:0] id, input logic [7:0] len,
                             input logic [7:0] err, input bit good_csum);
    logic [7:0] pkt[$];
    logic [7:0] sum;
    logic [7:0] b;
    pkt = '{HDR_BYTE, HDR_BYTE, id, len};
    if (len >= MIN_LEN) begin
      sum = id + len + err;
      pkt.push_back(err);
      for (int i = 0; i < int'(len) - 2; i++) begin
        b = $urandom_range(255);
        sum += b;
        pkt.push_back(b);
      end
      pkt.push_back(good_csum ? ~sum : ~sum ^ 8'($urandom_range(1, 255)));
    end
    foreach (pkt[i]) send_byte(pkt[i]);
    stream_bytes += pkt.size();
  endtask

  initial begin
    logic [7:0] directed[$];
    logic [7:0] len;
    int         pick;
    bit         held;
    bit         paused;

    held   = 1'b0;
    paused = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Noise, a broken header, an id of 0xFF with length zero, length one,
    // and a packet with extreme id, error and parameter bytes.
    directed = '{8'h00, 8'h7F, 8'hFF, 8'h00,
                 8'hFF, 8'hFF, 8'hFF, 8'h00,
                 8'hFF, 8'hFF, 8'h00, 8'h01,
                 8'hFF, 8'hFF, 8'hFE, 8'h04, 8'hFF, 8'h00, 8'hFF, 8'hFF};
    foreach (directed[i]) send_byte(directed[i]);
    send_packet(8'h01, 8'd2, 8'h00, 1'b1);
    send_packet(8'h80, 8'd3, 8'h55, 1'b0);
    wait_quiet();

    while (stream_bytes < TARGET_BYTES) begin
      // A long stretch with no idling on either side.
      if (stream_bytes >= 1200 && stream_bytes < 1500) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else begin
        src_idle_pct  = 33;
        sink_idle_pct = 33;
      end
      if (!held && stream_bytes >= 700) begin
        // The receiver stalls while a maximum-length packet keeps coming.
        held          = 1'b1;
        sink_hold_req = 300;
        send_packet(8'($urandom_range(255)), 8'd255, 8'($urandom_range(255)), 1'b1);
      end
      if (!paused && stream_bytes >= 1000) begin
        paused = 1'b1;
        wait_quiet();
      end
      pick = $urandom_range(99);
      if (pick < 75) begin
        pick = $urandom_range(199);
        if (pick < 6)       len = 8'($urandom_range(1));
        else if (pick == 6) len = 8'($urandom_range(254, 255));
        else                len = 8'($urandom_range(2, 12));
        send_packet(8'($urandom_range(255)), len, 8'($urandom_range(255)),
                    $urandom_range(99) < 75);
      end else if (pick < 88) begin
        // Truncated packet: the parser takes the next bytes as its remainder.
        directed = '{HDR_BYTE, HDR_BYTE, 8'($urandom_range(255)), 8'($urandom_range(2, 9))};
        repeat ($urandom_range(0, 4)) directed.push_back(8'($urandom_range(255)));
        foreach (directed[i]) send_byte(directed[i]);
        stream_bytes += directed.size();
      end else begin
        repeat ($urandom_range(1, 4))
          send_byte(($urandom_range(3) == 0) ? HDR_BYTE : 8'($urandom_range(255)));
      end
    end

    wait_quiet();
    if (model.fails == 0) begin
      $display("servo_status_packet_parser regression: pass");
    end else begin
      $display("servo_status_packet_parser regression: fail");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("servo_status_packet_parser regression: fail");
    $finish;
  end

endmodule
